// File: sv/ups_pkg.sv
// Shared widths, codes, state and command types for the unimodal peak search block.
package ups_pkg;

   localparam int INDEX_BITS   = 16;
   localparam int VALUE_BITS   = 32;
   localparam int MEMO_ENTRIES = 8;
   localparam int SLOT_BITS    = $clog2(MEMO_ENTRIES);

   // Span arithmetic carries one extra bit so sums past the index range stay exact
   localparam int DIV_BITS = INDEX_BITS + 1;
   localparam int PROD_BITS = 2 * DIV_BITS;

   // Reciprocal of three scaled by 2**DIV_BITS; the quotient needs at most one correction
   localparam logic [DIV_BITS-1:0] THIRD_RECIP = DIV_BITS'((64'd1 << DIV_BITS) / 64'd3);

   // Input item kinds
   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_RESPONSE = 1'b1;

   // Result item kinds
   localparam logic KIND_PROBE = 1'b0;
   localparam logic KIND_PEAK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAIT_L,
      ST_WAIT_R,
      ST_WAIT_S,
      ST_TERN,
      ST_DIV,
      ST_FIND_L,
      ST_FIND_R,
      ST_CMP,
      ST_SCAN,
      ST_SCAN_UPD
   } state_type;

   typedef enum logic [1:0] {
      KEY_LEFT,
      KEY_RIGHT,
      KEY_SCAN
   } key_sel_type;

   typedef struct packed {
      logic        start;
      logic        memo_put;
      logic        div_load;
      logic        split_load;
      key_sel_type key_sel;
      logic        memo_read;
      logic        vl_load;
      logic        narrow;
      logic        scan_init;
      logic        scan_update;
      logic        out_probe;
      logic        out_answer;
   } ctrl_cmd_type;

   typedef struct packed {
      logic span_small;
      logic scan_done;
      logic memo_hit;
      logic out_free;
   } ctrl_status_type;

endpackage

// File: sv/ups_req_if.sv
// Input channel interface: start and probe response items.
interface ups_req_if import ups_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [INDEX_BITS-1:0] item_count;
   logic [VALUE_BITS-1:0] probe_value;
   logic                  probe_failed;

   modport source (output valid, req_type, item_count, probe_value, probe_failed,
                   input ready);
   modport sink (input valid, req_type, item_count, probe_value, probe_failed,
                 output ready);
   modport monitor (input valid, ready, req_type, item_count, probe_value, probe_failed);
endinterface

// File: sv/ups_rsp_if.sv
// Result channel interface: probe requests and peak answers.
interface ups_rsp_if import ups_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [INDEX_BITS-1:0] probe_index;
   logic [VALUE_BITS-1:0] peak_value;

   modport source (output valid, result_kind, probe_index, peak_value, input ready);
   modport sink (input valid, result_kind, probe_index, peak_value, output ready);
   modport monitor (input valid, ready, result_kind, probe_index, peak_value);
endinterface

// File: sv/unimodal_peak_ternary_search.sv
// Top level of the unimodal peak search: sequencer plus datapath behind two channels.
//
// A start transfer opens a search over positions 1..item_count; the block then sends
// probe requests on the result channel and expects each answer as a response transfer,
// finishing with one peak result (index and value). Items are taken only while the block
// is idle or waiting for a probe response; a start in that window restarts the search,
// a response while idle is dropped and a failed response returns to idle. After a
// response transfer, each ternary round whose two points are already in the memo
// passes through lookup left, lookup right, compare, span test and divide-by-three
// correction, each scan point found in the memo passes through a lookup and an
// update, and the span test plus split come before the first lookup of a round.
// These steps come from the sequencer making its memo lookups one at a time through
// the single read port of the value memory and from the registered reciprocal
// multiply for the thirds. The memo holds eight entries with valid flags cleared on
// reset and on every start, so no clearing pass is needed. A result waiting on the
// output register does not block a transfer on the input channel.
module unimodal_peak_ternary_search import ups_pkg::*; (
   input logic   clock,
   input logic   reset,
   ups_req_if.sink   req_if,
   ups_rsp_if.source rsp_if
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ups_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_type     (req_if.req_type),
      .probe_failed (req_if.probe_failed),
      .req_ready    (req_if.ready),
      .status       (status),
      .cmd          (cmd)
   );

   ups_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .item_count  (req_if.item_count),
      .probe_value (req_if.probe_value),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_kind    (rsp_if.result_kind),
      .rsp_index   (rsp_if.probe_index),
      .rsp_value   (rsp_if.peak_value)
   );

endmodule

// File: sv/ups_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ups_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ups_controller.sv
// Search sequencer: walks ternary rounds, memo lookups, the final scan and the handshake.
module ups_controller import ups_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_type,
   input  logic            probe_failed,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.key_sel = KEY_LEFT;
      req_ready   = 1'b0;
      unique case (state_ff) inside
         ST_IDLE, ST_WAIT_L, ST_WAIT_R, ST_WAIT_S: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_START) begin
                  cmd.start = 1'b1;
                  state_in  = ST_TERN;
               end else if (state_ff != ST_IDLE) begin
                  if (probe_failed) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.memo_put = 1'b1;
                     state_in     = (state_ff == ST_WAIT_S) ? ST_SCAN : ST_FIND_L;
                  end
               end
            end
         end
         ST_TERN: begin
            if (status.span_small) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.split_load = 1'b1;
            state_in       = ST_FIND_L;
         end
         ST_FIND_L: begin
            cmd.key_sel   = KEY_LEFT;
            cmd.memo_read = 1'b1;
            if (status.memo_hit) begin
               state_in = ST_FIND_R;
            end else if (status.out_free) begin
               cmd.out_probe = 1'b1;
               state_in      = ST_WAIT_L;
            end
         end
         ST_FIND_R: begin
            // Left value sits on the read port until the right lookup hits
            cmd.key_sel   = KEY_RIGHT;
            cmd.vl_load   = 1'b1;
            cmd.memo_read = status.memo_hit;
            if (status.memo_hit) begin
               state_in = ST_CMP;
            end else if (status.out_free) begin
               cmd.out_probe = 1'b1;
               state_in      = ST_WAIT_R;
            end
         end
         ST_CMP: begin
            cmd.narrow = 1'b1;
            state_in   = ST_TERN;
         end
         ST_SCAN: begin
            cmd.key_sel   = KEY_SCAN;
            cmd.memo_read = 1'b1;
            if (status.scan_done) begin
               if (status.out_free) begin
                  cmd.out_answer = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (status.memo_hit) begin
               state_in = ST_SCAN_UPD;
            end else if (status.out_free) begin
               cmd.out_probe = 1'b1;
               state_in      = ST_WAIT_S;
            end
         end
         ST_SCAN_UPD: begin
            cmd.key_sel     = KEY_SCAN;
            cmd.scan_update = 1'b1;
            state_in        = ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/ups_datapath.sv
// Span registers, divide-by-three, memo lookup, scan best tracking and result register.
module ups_datapath import ups_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   input  logic [INDEX_BITS-1:0] item_count,
   input  logic [VALUE_BITS-1:0] probe_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_kind,
   output logic [INDEX_BITS-1:0] rsp_index,
   output logic [VALUE_BITS-1:0] rsp_value
);

   // Search registers
   logic [INDEX_BITS-1:0] length_ff, length_in;
   logic [INDEX_BITS-1:0] low_ff, low_in;
   logic [INDEX_BITS-1:0] high_ff, high_in;
   logic [DIV_BITS-1:0]   div_x_ff, div_x_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [INDEX_BITS-1:0] lc_ff, lc_in;
   logic [INDEX_BITS-1:0] rc_ff, rc_in;
   logic [VALUE_BITS-1:0] vl_ff, vl_in;
   logic [INDEX_BITS-1:0] pos_ff, pos_in;
   logic [VALUE_BITS-1:0] best_value_ff, best_value_in;
   logic [INDEX_BITS-1:0] best_index_ff, best_index_in;
   logic                  best_valid_ff, best_valid_in;
   logic [INDEX_BITS-1:0] pending_ff, pending_in;

   // Memo tags and fill pointer
   logic [INDEX_BITS-1:0]   memo_index_ff [MEMO_ENTRIES];
   logic [INDEX_BITS-1:0]   memo_index_in [MEMO_ENTRIES];
   logic [MEMO_ENTRIES-1:0] memo_valid_ff, memo_valid_in;
   logic [SLOT_BITS-1:0]    ptr_ff, ptr_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;

   // Combinational terms
   logic [DIV_BITS-1:0]   span_x;
   logic [DIV_BITS-1:0]   quot_est;
   logic [DIV_BITS-1:0]   quot_rem;
   logic [DIV_BITS-1:0]   d3;
   logic [DIV_BITS-1:0]   lc_sum;
   logic [INDEX_BITS-1:0] lc_new;
   logic [DIV_BITS-1:0]   rc_raw;
   logic [DIV_BITS-1:0]   lc_plus;
   logic [DIV_BITS-1:0]   rc_adj;
   logic [INDEX_BITS-1:0] rc_new;
   logic [INDEX_BITS-1:0] scan_p;
   logic [INDEX_BITS-1:0] key;
   logic                  hit_any;
   logic [SLOT_BITS-1:0]  hit_slot;
   logic [VALUE_BITS-1:0] memo_rd;
   logic                  out_free;

   // Span test and divide by three: reciprocal product, then one correction step
   assign span_x   = {1'b0, high_ff} - {1'b0, low_ff} + DIV_BITS'(2);
   assign quot_est = prod_ff[PROD_BITS-1:DIV_BITS];
   assign quot_rem = div_x_ff - (quot_est + (quot_est << 1));
   assign d3       = (quot_rem >= DIV_BITS'(3)) ? quot_est + DIV_BITS'(1) : quot_est;

   // Inner points, clamped to the length; keep the right point past the left one
   assign lc_sum  = {1'b0, low_ff} + d3;
   assign lc_new  = (lc_sum < {1'b0, length_ff}) ? lc_sum[INDEX_BITS-1:0] : length_ff;
   assign rc_raw  = {1'b0, high_ff} - d3;
   assign lc_plus = {1'b0, lc_new} + DIV_BITS'(1);
   assign rc_adj  = (rc_raw < lc_plus) ? lc_plus : rc_raw;
   assign rc_new  = (rc_adj < {1'b0, length_ff}) ? rc_adj[INDEX_BITS-1:0] : length_ff;

   assign scan_p   = (pos_ff < length_ff) ? pos_ff : length_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Select lookup key
   always_comb begin
      case (cmd.key_sel)
         KEY_LEFT:  key = lc_ff;
         KEY_RIGHT: key = rc_ff;
         KEY_SCAN:  key = scan_p;
         default:   key = lc_ff;
      endcase
   end

   // Match key against held tags, lowest slot wins
   always_comb begin
      hit_any  = 1'b0;
      hit_slot = '0;
      for (int i = MEMO_ENTRIES - 1; i >= 0; i--) begin
         if (memo_valid_ff[i] && (memo_index_ff[i] == key)) begin
            hit_any  = 1'b1;
            hit_slot = SLOT_BITS'(i);
         end
      end
   end

   ups_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MEMO_ENTRIES)
   ) u_memo_ram (
      .clock   (clock),
      .wr_en   (cmd.memo_put),
      .wr_addr (ptr_ff),
      .wr_data (probe_value),
      .rd_en   (cmd.memo_read),
      .rd_addr (hit_slot),
      .rd_data (memo_rd)
   );

   // Status back to the sequencer
   assign status = '{
      span_small: ({1'b0, high_ff} < ({1'b0, low_ff} + DIV_BITS'(3))),
      scan_done:  (pos_ff > high_ff),
      memo_hit:   hit_any,
      out_free:   out_free
   };

   // Next values
   always_comb begin
      length_in     = length_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      div_x_in      = div_x_ff;
      prod_in       = prod_ff;
      lc_in         = lc_ff;
      rc_in         = rc_ff;
      vl_in         = vl_ff;
      pos_in        = pos_ff;
      best_value_in = best_value_ff;
      best_index_in = best_index_ff;
      best_valid_in = best_valid_ff;
      pending_in    = pending_ff;
      memo_index_in = memo_index_ff;
      memo_valid_in = memo_valid_ff;
      ptr_in        = ptr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;

      // Open a new search and flush the memo
      if (cmd.start) begin
         length_in     = item_count;
         low_in        = INDEX_BITS'(1);
         high_in       = item_count;
         best_valid_in = 1'b0;
         best_value_in = '0;
         best_index_in = '0;
         pos_in        = '0;
         pending_in    = '0;
         memo_valid_in = '0;
         ptr_in        = '0;
      end

      // Record the probe response in the next slot in turn
      if (cmd.memo_put) begin
         memo_index_in[ptr_ff] = pending_ff;
         memo_valid_in[ptr_ff] = 1'b1;
         ptr_in = (ptr_ff == SLOT_BITS'(MEMO_ENTRIES - 1)) ? '0 : ptr_ff + SLOT_BITS'(1);
      end

      if (cmd.div_load) begin
         div_x_in = span_x;
         prod_in  = PROD_BITS'(span_x) * PROD_BITS'(THIRD_RECIP);
      end

      if (cmd.split_load) begin
         lc_in = lc_new;
         rc_in = rc_new;
      end

      if (cmd.vl_load) begin
         vl_in = memo_rd;
      end

      // Narrow the span; equal values keep the middle third
      if (cmd.narrow) begin
         if (vl_ff < memo_rd) begin
            low_in = lc_ff;
         end else if (vl_ff > memo_rd) begin
            high_in = rc_ff;
         end else begin
            low_in  = lc_ff;
            high_in = rc_ff;
         end
      end

      if (cmd.scan_init) begin
         pos_in        = low_ff;
         best_valid_in = 1'b0;
         best_value_in = '0;
         best_index_in = '0;
      end

      // Track the maximum, ties go to the later point; advance or finish
      if (cmd.scan_update) begin
         if (!best_valid_ff || (memo_rd >= best_value_ff)) begin
            best_valid_in = 1'b1;
            best_value_in = memo_rd;
            best_index_in = scan_p;
         end
         if (pos_ff == high_ff) begin
            high_in = '0;
            pos_in  = INDEX_BITS'(1);
         end else begin
            pos_in = pos_ff + INDEX_BITS'(1);
         end
      end

      // Drop the result after its transfer, then load a new one
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_probe) begin
         pending_in   = key;
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_PROBE;
         rsp_index_in = key;
         rsp_value_in = '0;
      end
      if (cmd.out_answer) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_PEAK;
         rsp_index_in = best_index_ff;
         rsp_value_in = best_value_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         memo_valid_ff <= '0;
         ptr_ff        <= '0;
         best_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         memo_valid_ff <= memo_valid_in;
         ptr_ff        <= ptr_in;
         best_valid_ff <= best_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      length_ff     <= length_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      div_x_ff      <= div_x_in;
      prod_ff       <= prod_in;
      lc_ff         <= lc_in;
      rc_ff         <= rc_in;
      vl_ff         <= vl_in;
      pos_ff        <= pos_in;
      best_value_ff <= best_value_in;
      best_index_ff <= best_index_in;
      pending_ff    <= pending_in;
      memo_index_ff <= memo_index_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// File: sv/ups_checker.sv
// Port-level checker for the unimodal peak search, bound to the top level.
module ups_checker import ups_pkg::*; (
   input logic       clock,
   input logic       reset,
   ups_req_if.sink   req_if,
   ups_rsp_if.source rsp_if
);

   // Hold a result until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> rsp_if.valid)
      else $error("result dropped before its transfer");

   // A start transfer puts the block to work, so it takes nothing in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.req_type == REQ_START)) |=> !req_if.ready)
      else $error("input taken right after a start");

   // Probe requests carry a real position and no value
   a_probe_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.result_kind == KIND_PROBE)) |->
         ((rsp_if.probe_index != '0) && (rsp_if.peak_value == '0)))
      else $error("malformed probe request");

   // An answer without a peak position carries a zero value
   a_empty_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.result_kind == KIND_PEAK) && (rsp_if.probe_index == '0)) |->
         (rsp_if.peak_value == '0))
      else $error("empty answer with nonzero value");

endmodule

bind unimodal_peak_ternary_search ups_checker u_ups_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the unimodal peak ternary search block.
module tb;
   import ups_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int ITEM_TARGET = 700;

   // Kinds of pending stimulus: a start, a response taken from the active curve,
   // a response with a fixed payload, and a pause until all results are back
   typedef enum logic [1:0] {OP_START, OP_CURVE, OP_RAW, OP_DRAIN} stim_op_type;

   typedef struct {
      stim_op_type           op;
      logic [INDEX_BITS-1:0] count;
      logic [VALUE_BITS-1:0] value;
      logic                  failed;
      int unsigned           peak_pos;
      logic [VALUE_BITS-1:0] peak_val;
      longint unsigned       slope;
      int unsigned           stair;
   } stim_type;

   typedef struct {
      logic                  kind;
      logic [INDEX_BITS-1:0] index;
      logic [VALUE_BITS-1:0] value;
   } result_type;

   typedef enum logic [2:0] {
      SP_IDLE, SP_TERN, SP_WAIT_L, SP_WAIT_R, SP_SCAN, SP_WAIT_S
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_kind = REQ_START;
   logic [INDEX_BITS-1:0] req_count = '0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  req_failed = 1'b0;
   logic                  rsp_ready = 1'b0;

   ups_req_if req_ch ();
   ups_rsp_if rsp_ch ();

   assign req_ch.valid        = req_valid;
   assign req_ch.req_type     = req_kind;
   assign req_ch.item_count   = req_count;
   assign req_ch.probe_value  = req_value;
   assign req_ch.probe_failed = req_failed;
   assign rsp_ch.ready        = rsp_ready;

   unimodal_peak_ternary_search uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   stim_type   stim_q[$];
   result_type expected_q[$];
   int         errors = 0;
   int         planned_items = 0;

   // Search state mirrored from the accepted transfers
   phase_type             phase = SP_IDLE;
   int unsigned           span_lo = 1;
   int unsigned           span_hi = 0;
   int unsigned           seq_len = 0;
   int unsigned           pend_idx = 0;
   int unsigned           scan_pos = 0;
   logic [VALUE_BITS-1:0] best_val = '0;
   logic                  best_ok = 1'b0;
   int unsigned           best_idx = 0;
   int unsigned           memo_idx[MEMO_ENTRIES];
   logic [VALUE_BITS-1:0] memo_val[MEMO_ENTRIES];
   logic                  memo_ok[MEMO_ENTRIES];
   int unsigned           memo_wr = 0;

   // Sequence the partner answers with during the current search
   int unsigned           c_peak_pos = 1;
   logic [VALUE_BITS-1:0] c_peak_val = '0;
   longint unsigned       c_slope = 0;
   int unsigned           c_stair = 1;

   function automatic int unsigned clamp_len(input int unsigned v);
      return (v < seq_len) ? v : seq_len;
   endfunction

   function automatic logic memo_lookup(input int unsigned idx,
                                        output logic [VALUE_BITS-1:0] val);
      val = '0;
      for (int i = 0; i < MEMO_ENTRIES; i++) begin
         if (memo_ok[i] && memo_idx[i] == idx) begin
            val = memo_val[i];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void issue_probe(input int unsigned idx, input phase_type wait_phase);
      result_type r;
      pend_idx = idx;
      phase    = wait_phase;
      r.kind   = KIND_PROBE;
      r.index  = INDEX_BITS'(idx);
      r.value  = '0;
      expected_q.push_back(r);
   endfunction

   // Run the search forward until a probe is needed or the peak is known
   function automatic void search_advance();
      int unsigned           third, lc, rc, p;
      logic [VALUE_BITS-1:0] vl, vr, v;
      logic                  busy;
      result_type            r;
      busy = 1'b1;
      while (busy) begin
         if (phase == SP_TERN) begin
            if (span_hi < span_lo + 3) begin
               phase    = SP_SCAN;
               scan_pos = span_lo;
               best_ok  = 1'b0;
               best_val = '0;
               best_idx = 0;
            end else begin
               third = (span_hi - span_lo + 2) / 3;
               lc = clamp_len(span_lo + third);
               rc = span_hi - third;
               if (rc < lc + 1) rc = lc + 1;
               rc = clamp_len(rc);
               if (!memo_lookup(lc, vl)) begin
                  issue_probe(lc, SP_WAIT_L);
                  busy = 1'b0;
               end else if (!memo_lookup(rc, vr)) begin
                  issue_probe(rc, SP_WAIT_R);
                  busy = 1'b0;
               end else if (vl < vr) begin
                  span_lo = lc;
               end else if (vl > vr) begin
                  span_hi = rc;
               end else begin
                  span_lo = lc;
                  span_hi = rc;
               end
            end
         end else if (phase == SP_SCAN) begin
            if (scan_pos > span_hi) begin
               phase   = SP_IDLE;
               r.kind  = KIND_PEAK;
               r.index = best_ok ? INDEX_BITS'(best_idx) : '0;
               r.value = best_ok ? best_val : '0;
               expected_q.push_back(r);
               busy = 1'b0;
            end else begin
               p = clamp_len(scan_pos);
               if (!memo_lookup(p, v)) begin
                  issue_probe(p, SP_WAIT_S);
                  busy = 1'b0;
               end else begin
                  // ties go to the later position
                  if (!best_ok || v >= best_val) begin
                     best_ok  = 1'b1;
                     best_val = v;
                     best_idx = p;
                  end
                  if (scan_pos == span_hi) begin
                     span_hi  = 0;
                     scan_pos = 1;
                  end else begin
                     scan_pos++;
                  end
               end
            end
         end else begin
            busy = 1'b0;
         end
      end
   endfunction

   // Apply one accepted transfer to the mirrored state and queue its results
   function automatic void search_accept(input stim_type it);
      if (it.op == OP_START) begin
         seq_len  = it.count;
         span_lo  = 1;
         span_hi  = seq_len;
         best_ok  = 1'b0;
         best_val = '0;
         best_idx = 0;
         scan_pos = 0;
         pend_idx = 0;
         for (int i = 0; i < MEMO_ENTRIES; i++) memo_ok[i] = 1'b0;
         memo_wr = 0;
         phase   = SP_TERN;
         search_advance();
      end else if (phase inside {SP_WAIT_L, SP_WAIT_R, SP_WAIT_S}) begin
         if (it.failed) begin
            phase = SP_IDLE;
         end else begin
            memo_idx[memo_wr] = pend_idx;
            memo_val[memo_wr] = it.value;
            memo_ok[memo_wr]  = 1'b1;
            memo_wr = (memo_wr + 1) % MEMO_ENTRIES;
            phase = (phase == SP_WAIT_S) ? SP_SCAN : SP_TERN;
            search_advance();
         end
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] curve_value(input int unsigned idx);
      longint unsigned offset, drop;
      offset = (idx > c_peak_pos) ? idx - c_peak_pos : c_peak_pos - idx;
      drop = (offset / c_stair) * c_slope;
      return (drop >= c_peak_val) ? '0 : VALUE_BITS'(c_peak_val - drop);
   endfunction

   // Rough count of responses a search of this length needs
   function automatic int unsigned curve_budget(input int unsigned n);
      int unsigned span, k;
      span = n;
      k = 0;
      while (span >= 4) begin
         span = span - (span + 2) / 3;
         k += 2;
      end
      return k + span + 2;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_start(input int unsigned n, input logic failed);
      stim_type s;
      int unsigned r;
      s.op       = OP_START;
      s.count    = INDEX_BITS'(n);
      s.value    = $urandom;
      s.failed   = failed;
      r = $urandom_range(0, 9);
      s.peak_pos = (n == 0 || r == 0) ? 1 : (r == 1) ? n : $urandom_range(1, n);
      s.peak_val = ($urandom_range(0, 9) == 0) ? '1 : VALUE_BITS'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) s.slope = 0;
      else if (r < 6) s.slope = $urandom_range(1, 16);
      else if (r < 8) s.slope = $urandom;
      else s.slope = $urandom_range(1, 1000);
      s.stair    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1;
      stim_q.push_back(s);
      planned_items++;
   endfunction

   function automatic void add_curves(input int unsigned k);
      stim_type s;
      s.op       = OP_CURVE;
      s.count    = INDEX_BITS'($urandom);
      s.value    = '0;
      s.failed   = 1'b0;
      s.peak_pos = 1;
      s.peak_val = '0;
      s.slope    = 0;
      s.stair    = 1;
      repeat (k) stim_q.push_back(s);
      planned_items += k;
   endfunction

   function automatic void add_raw(input logic [VALUE_BITS-1:0] v, input logic failed);
      stim_type s;
      s.op       = OP_RAW;
      s.count    = INDEX_BITS'($urandom);
      s.value    = v;
      s.failed   = failed;
      s.peak_pos = 1;
      s.peak_val = '0;
      s.slope    = 0;
      s.stair    = 1;
      stim_q.push_back(s);
      planned_items++;
   endfunction

   function automatic void add_drain();
      stim_type s;
      s.op       = OP_DRAIN;
      s.count    = '0;
      s.value    = '0;
      s.failed   = 1'b0;
      s.peak_pos = 1;
      s.peak_val = '0;
      s.slope    = 0;
      s.stair    = 1;
      stim_q.push_back(s);
   endfunction

   // Sender: present pending items, apply each transfer to the mirrored state
   stim_type    offer;
   logic        offering = 1'b0;
   int unsigned send_gap = 0;
   logic        send_calm = 1'b0;
   int unsigned sent_items = 0;

   always @(posedge clock) begin
      stim_type head;
      logic     scanning;
      if (reset) begin
         req_valid <= 1'b0;
         offering  = 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ch.ready) begin
            if (offer.op == OP_START) begin
               c_peak_pos = offer.peak_pos;
               c_peak_val = offer.peak_val;
               c_slope    = offer.slope;
               c_stair    = offer.stair;
            end
            search_accept(offer);
            offering = 1'b0;
            sent_items++;
            if (sent_items % 48 == 0) send_calm = ($urandom_range(0, 3) == 0);
            send_gap = send_calm ? 0 : pick_gap();
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else begin
               scanning = 1'b1;
               while (scanning && stim_q.size() > 0) begin
                  head = stim_q[0];
                  if (head.op == OP_DRAIN) begin
                     if (expected_q.size() == 0) void'(stim_q.pop_front());
                     else scanning = 1'b0;
                  end else begin
                     // a spare response after the search is over still goes out
                     offer = stim_q.pop_front();
                     if (offer.op == OP_CURVE) offer.value = curve_value(pend_idx);
                     offering = 1'b1;
                     scanning = 1'b0;
                  end
               end
            end
         end
         req_valid <= offering;
         if (offering) begin
            req_kind   <= (offer.op == OP_START) ? REQ_START : REQ_RESPONSE;
            req_count  <= offer.count;
            req_value  <= offer.value;
            req_failed <= offer.failed;
         end
      end
   end

   // Receiver: random stalls, two long hold-offs, check every result transfer
   int unsigned results_seen = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   logic        recv_calm = 1'b0;

   always @(posedge clock) begin
      result_type want;
      logic       rdy;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] unexpected result: kind %0d index %0d value %08h",
                           $realtime, rsp_ch.result_kind, rsp_ch.probe_index,
                           rsp_ch.peak_value);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.result_kind !== want.kind || rsp_ch.probe_index !== want.index ||
                   rsp_ch.peak_value !== want.value) begin
                  errors++;
                  if (errors <= 10)
                     $display("[%0t] mismatch: exp %0d/%0d/%08h got %0d/%0d/%08h",
                              $realtime, want.kind, want.index, want.value,
                              rsp_ch.result_kind, rsp_ch.probe_index, rsp_ch.peak_value);
               end
            end
            if (results_seen == 120 || results_seen == 300) hold_left = HOLDOFF_CYCLES;
            if (results_seen % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
            if (!recv_calm) stall_left = pick_gap();
         end
         rsp_ready <= rdy;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned n, k, r;
      for (int i = 0; i < MEMO_ENTRIES; i++) begin
         memo_idx[i] = 0;
         memo_val[i] = '0;
         memo_ok[i]  = 1'b0;
      end

      // Directed: stray response while idle, zero length, single point at full scale
      add_raw(32'h1234_5678, 1'b0);
      add_start(0, 1'b0);
      add_start(1, 1'b1);
      add_raw('1, 1'b0);
      // flat scan: the later position wins the tie
      add_start(3, 1'b0);
      add_raw(5, 1'b0);
      add_raw(5, 1'b0);
      add_raw(5, 1'b0);
      // equal thirds, then the scan runs entirely from the memo
      add_start(4, 1'b0);
      add_raw(7, 1'b0);
      add_raw(7, 1'b0);
      // longest length, then the partner fails
      add_start(16'hFFFF, 1'b0);
      add_raw('0, 1'b0);
      add_raw('1, 1'b0);
      add_raw(32'hA5A5_5A5A, 1'b1);
      add_raw(9, 1'b0);
      // restart in the middle of a search
      add_start(10, 1'b0);
      add_curves(2);
      add_start(2, 1'b0);
      add_curves(3);
      add_drain();

      // Random searches: mostly complete, some cut short, failed or disturbed
      while (planned_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 55) n = $urandom_range(1, 24);
         else if (r < 80) n = $urandom_range(25, 300);
         else if (r < 93) n = $urandom_range(301, 5000);
         else if (r < 98) n = $urandom_range(5001, 65535);
         else n = 65535;
         add_start(n, $urandom_range(0, 9) == 0);
         k = curve_budget(n);
         r = $urandom_range(0, 99);
         if (r < 8) begin
            add_curves($urandom_range(0, k / 2));
         end else if (r < 14) begin
            add_curves($urandom_range(0, k / 2));
            add_raw($urandom, 1'b1);
         end else if (r < 20) begin
            add_curves($urandom_range(0, k / 2));
            add_raw($urandom, 1'b0);
            add_curves(k);
         end else begin
            add_curves(k);
         end
         if ($urandom_range(0, 19) == 0) add_raw($urandom, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 11) == 0) add_drain();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transfer, then for every result, then let the block settle
      while (stim_q.size() != 0 || offering) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: unimodal_peak_ternary_search.f
sv/ups_pkg.sv
sv/ups_req_if.sv
sv/ups_rsp_if.sv
sv/ups_ram.sv
sv/ups_controller.sv
sv/ups_datapath.sv
sv/unimodal_peak_ternary_search.sv
sv/ups_checker.sv
tb/sv/tb.sv
